[rtl/midi_byte_stream_parser_macros.svh]
// Assertion helpers shared by the checker.
`ifndef MIDI_BYTE_STREAM_PARSER_MACROS_SVH
`define MIDI_BYTE_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define MBSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define MBSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mbsp_pkg.sv]
package mbsp_pkg;

    localparam logic [7:0] RT_FIRST     = 8'hF8;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] PROG_CHANGE  = 8'hC0;
    localparam logic [7:0] CHAN_PRESS   = 8'hD0;
    localparam logic [7:0] MTC_QFRAME   = 8'hF1;
    localparam logic [7:0] SONG_SELECT  = 8'hF3;
    localparam logic [7:0] SONG_POS     = 8'hF2;

    localparam logic [1:0] LEN_ONE      = 2'd1;
    localparam logic [1:0] LEN_TWO      = 2'd2;
    localparam logic [1:0] LEN_THREE    = 2'd3;

    typedef struct packed {
        logic       sysex_active;
        logic [7:0] chan_status;
        logic [1:0] chan_count;
        logic [1:0] chan_expected;
        logic [7:0] sys_status;
        logic [1:0] sys_count;
        logic [1:0] sys_expected;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] msg_length;
        logic [7:0] msg_byte0;
        logic [6:0] msg_byte1;
        logic [6:0] msg_byte2;
    } midi_msg_t;

    typedef struct packed {
        logic       wr_en;
        logic       wr_idx;
    } store_wr_t;

endpackage

[rtl/mbsp_decode.sv]
module mbsp_decode (
    input  logic [7:0]            in_byte,
    input  mbsp_pkg::parse_state_t state,
    input  logic [6:0]            store0,
    input  logic [6:0]            store1,
    output mbsp_pkg::parse_state_t state_next,
    output mbsp_pkg::store_wr_t   store_wr,
    output logic                  msg_valid,
    output mbsp_pkg::midi_msg_t   msg
);
    import mbsp_pkg::*;

    logic [1:0] len;
    logic       use_store;
    logic [1:0] sys_need;
    logic [1:0] cnt_new;
    logic [6:0] data0_eff;
    logic [6:0] data1_eff;

    always_comb
    begin
        if (in_byte == MTC_QFRAME || in_byte == SONG_SELECT)
            sys_need = 2'd1;
        else if (in_byte == SONG_POS)
            sys_need = 2'd2;
        else
            sys_need = 2'd0;
    end

    always_comb
    begin
        state_next      = state;
        store_wr.wr_en  = 1'b0;
        store_wr.wr_idx = 1'b0;
        msg_valid       = 1'b0;
        len             = LEN_ONE;
        use_store       = 1'b0;
        msg.msg_byte0   = in_byte;
        cnt_new         = 2'd0;

        if (in_byte >= RT_FIRST) begin
            msg_valid = 1'b1;
        end else if (state.sysex_active) begin
            state_next.sysex_active = (in_byte != SYSEX_END);
            msg_valid = 1'b1;
        end else if (in_byte[7]) begin
            state_next.sys_status   = 8'd0;
            state_next.sys_count    = 2'd0;
            state_next.sys_expected = 2'd0;
            if (in_byte >= SYSEX_START) begin
                state_next.chan_status   = 8'd0;
                state_next.chan_count    = 2'd0;
                state_next.chan_expected = 2'd0;
                state_next.sysex_active  = (in_byte == SYSEX_START);
                state_next.sys_expected  = sys_need;
                if (sys_need != 2'd0)
                    state_next.sys_status = in_byte;
                else
                    msg_valid = 1'b1;
            end else begin
                state_next.chan_status = in_byte;
                state_next.chan_count  = 2'd0;
                if ((in_byte & 8'hF0) == PROG_CHANGE || (in_byte & 8'hF0) == CHAN_PRESS)
                    state_next.chan_expected = 2'd1;
                else
                    state_next.chan_expected = 2'd2;
            end
        end else if (state.sys_status != 8'd0) begin
            cnt_new = state.sys_count;
            if (state.sys_count < 2'd2) begin
                store_wr.wr_en  = 1'b1;
                store_wr.wr_idx = state.sys_count[0];
                cnt_new         = state.sys_count + 2'd1;
            end
            state_next.sys_count = cnt_new;
            if (cnt_new >= state.sys_expected) begin
                state_next.sys_status   = 8'd0;
                state_next.sys_count    = 2'd0;
                state_next.sys_expected = 2'd0;
                msg_valid     = 1'b1;
                use_store     = 1'b1;
                msg.msg_byte0 = state.sys_status;
                len = (state.sys_expected > 2'd1) ? LEN_THREE : LEN_TWO;
            end
        end else if (state.chan_status != 8'd0) begin
            cnt_new = state.chan_count;
            if (state.chan_count < 2'd2) begin
                store_wr.wr_en  = 1'b1;
                store_wr.wr_idx = state.chan_count[0];
                cnt_new         = state.chan_count + 2'd1;
            end
            state_next.chan_count = cnt_new;
            if (cnt_new >= state.chan_expected) begin
                state_next.chan_count = 2'd0;
                msg_valid     = 1'b1;
                use_store     = 1'b1;
                msg.msg_byte0 = state.chan_status;
                len = (state.chan_expected > 2'd1) ? LEN_THREE : LEN_TWO;
            end
        end

        // bypass the byte written this beat
        data0_eff = (store_wr.wr_en && !store_wr.wr_idx) ? in_byte[6:0] : store0;
        data1_eff = (store_wr.wr_en &&  store_wr.wr_idx) ? in_byte[6:0] : store1;

        msg.msg_length = len;
        msg.msg_byte1  = use_store ? data0_eff : 7'd0;
        msg.msg_byte2  = (use_store && len == LEN_THREE) ? data1_eff : 7'd0;
    end

endmodule

[rtl/midi_byte_stream_parser.sv]
// MIDI byte stream parser.
// Slave stream s_axis: one raw MIDI byte per beat in tdata[7:0].
// Master stream m_axis: one assembled message per beat, 24-bit tdata:
//   [1:0] length (1..3), [9:2] status or passed byte, [16:10] data 1,
//   [23:17] data 2 (unused data bytes read as zero).
// Real-time bytes, sysex contents and system statuses other than F1..F3
// come out as one-byte messages; channel and system common messages come
// out once all data is in. Channel and system common status bytes and
// stray data bytes produce no output beat.
// A byte taken into the input register has its message loaded into the
// output register once it is free, visible on m_axis from then on (two
// register stages). Throughput: one byte per cycle unless m_axis stalls;
// one level of decode logic between the registers updates the parse state.
// Reset clears running status, sysex mode and both stream valids.
// When m_axis_tready is low the output beat holds; the input register
// still takes one more byte, then s_axis_tready drops until the
// output drains.
module midi_byte_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // msg_length, msg_byte0, msg_byte1, msg_byte2
);
    import mbsp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [6:0]   store_reg [2];
    store_wr_t    store_wr;
    logic         out_valid_reg;
    midi_msg_t    out_msg_reg;
    logic         msg_valid;
    midi_msg_t    msg;
    logic         out_load;
    logic         fire;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;

    mbsp_decode u_decode (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .store0     (store_reg[0]),
        .store1     (store_reg[1]),
        .state_next (state_next),
        .store_wr   (store_wr),
        .msg_valid  (msg_valid),
        .msg        (msg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire) begin
                state_reg     <= state_next;
                out_valid_reg <= msg_valid;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
        if (fire && msg_valid)
            out_msg_reg <= msg;
        if (fire && store_wr.wr_en)
            store_reg[store_wr.wr_idx] <= in_byte_reg[6:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_msg_reg.msg_byte2, out_msg_reg.msg_byte1,
                            out_msg_reg.msg_byte0, out_msg_reg.msg_length};

endmodule

[rtl/mbsp_checker.sv]
`include "midi_byte_stream_parser_macros.svh"

module mbsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import mbsp_pkg::*;

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00);

    `MBSP_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    `MBSP_ASSERT_IMP(a_len_nonzero, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd0, "zero-length message")
    `MBSP_ASSERT_IMP(a_single_clean, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] == LEN_ONE, m_axis_tdata[23:10] == 14'd0, "data bytes set on one-byte message")
    `MBSP_ASSERT_IMP(a_multi_status, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] != LEN_ONE, m_axis_tdata[9] && m_axis_tdata[23:17] == 7'd0 || m_axis_tdata[9] && m_axis_tdata[1:0] == LEN_THREE, "bad multi-byte message")
    `MBSP_ASSERT_NXT(a_rt_pass, clk, rst_n, s_beat && s_axis_tdata >= RT_FIRST && !m_axis_tvalid, ##1 m_axis_tvalid, "real-time byte not passed")

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
